/* design/tts_pkg.sv */
package tts_pkg;

  localparam int LN_IDX_W = 4;
  localparam int LN_REM_W = 27;
  localparam int LN_TAB_W = 20;
  localparam int LN_W = 25;
  localparam int NORM_W = 32;
  localparam int K_W = 5;
  localparam int L2_W = 30;
  localparam int L3_W = 35;
  localparam int PB_W = 37;
  localparam int PC_W = 35;
  localparam int D_W = 37;
  localparam int KEL_W = 30;
  localparam int KNUM_HI_W = 34;
  localparam int TEMP_W = 7;
  localparam int DIGIT_W = 4;
  localparam int LIMIT_W = 8;
  localparam int OHMS_W = 16;
  localparam int WR_IDX_W = 2;

  localparam logic [WR_IDX_W-1:0] REG_CHANGE_LIMIT = 2'd0;
  localparam logic [WR_IDX_W-1:0] REG_SERIES_OHMS = 2'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;
  localparam logic [OHMS_W-1:0] OHMS_RESET = 16'd10000;
  localparam logic [LIMIT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 7'd99;

  localparam logic [19:0] LN2_Q20 = 20'd726817;
  localparam logic [33:0] COEF_A = 34'd11291480000;
  localparam logic [31:0] COEF_B = 32'd2341250000;
  localparam logic [19:0] COEF_C = 20'd876741;
  localparam logic [63:0] KELVIN_NUM = 64'd10000000000000 << 20;
  localparam logic [KNUM_HI_W-1:0] KNUM_HI = KELVIN_NUM[63:KEL_W];
  localparam logic [KEL_W-1:0] KNUM_LO = KELVIN_NUM[KEL_W-1:0];
  localparam logic [KEL_W-1:0] ZERO_C_Q20 = 30'd286418534;
  localparam logic [KEL_W-1:0] KEL_LOW_LIM = 30'd285369958;
  localparam logic [KEL_W-1:0] KEL_HIGH_LIM = 30'd391276134;

  typedef struct packed {
    logic avail;
    logic bad;
  } q_head_t;

  function automatic logic [LN_TAB_W-1:0] ln_tab(input logic [LN_IDX_W:0] i);
    case (i)
      5'd0: ln_tab = 20'd0;
      5'd1: ln_tab = 20'd63570;
      5'd2: ln_tab = 20'd123504;
      5'd3: ln_tab = 20'd180198;
      5'd4: ln_tab = 20'd233983;
      5'd5: ln_tab = 20'd285143;
      5'd6: ln_tab = 20'd333923;
      5'd7: ln_tab = 20'd380534;
      5'd8: ln_tab = 20'd425161;
      5'd9: ln_tab = 20'd467966;
      5'd10: ln_tab = 20'd509092;
      5'd11: ln_tab = 20'd548665;
      5'd12: ln_tab = 20'd586800;
      5'd13: ln_tab = 20'd623596;
      5'd14: ln_tab = 20'd659144;
      5'd15: ln_tab = 20'd693527;
      5'd16: ln_tab = 20'd726817;
      default: ln_tab = 20'd0;
    endcase
  endfunction

  function automatic logic [DIGIT_W-1:0] tens_of(input logic [TEMP_W-1:0] t);
    logic [17:0] p;
    p = 18'(t) * 18'd205;
    tens_of = p[14:11];
  endfunction

endpackage

/* design/tts_front.sv */
module tts_front
  import tts_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] adc_sample,
  input  logic                pop,
  output q_head_t             head,
  output logic [ADC_BITS-1:0] head_sample
);

  logic [ADC_BITS-1:0] sample_q [2];
  logic                bad_q [2];
  logic                rd_ptr;
  logic                wr_ptr;
  logic [1:0]          count;
  logic                push;
  logic                take;

  assign in_ready    = (count != 2'd2);
  assign push        = in_valid && in_ready;
  assign take        = pop && (count != 2'd0);
  assign head.avail  = (count != 2'd0);
  assign head.bad    = bad_q[rd_ptr];
  assign head_sample = sample_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      sample_q[wr_ptr] <= adc_sample;
      bad_q[wr_ptr]    <= (adc_sample == '0) || (adc_sample == '1);
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      if (push && !take) count <= count + 2'd1;
      else if (take && !push) count <= count - 2'd1;
    end
  end

endmodule

/* design/tts_back.sv */
module tts_back
  import tts_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [LIMIT_W-1:0]  change_limit,
  input  logic [OHMS_W-1:0]   series_ohms,
  input  q_head_t             head,
  input  logic [ADC_BITS-1:0] head_sample,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TEMP_W-1:0]   shown_temp,
  output logic [DIGIT_W-1:0]  tens_digit,
  output logic [DIGIT_W-1:0]  units_digit,
  output logic                out_of_range
);

  localparam int NW = ADC_BITS + OHMS_W;
  localparam int CW = $clog2(NW);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV1, S_SUB, S_NORM, S_LN1, S_LN2, S_SQ,
    S_CUBE, S_COEF, S_SUM, S_DIV2, S_CEL, S_FILT
  } state_t;

  state_t              state;
  logic [ADC_BITS-1:0] samp;
  logic [NW-1:0]       num;
  logic [ADC_BITS-1:0] rem1;
  logic [CW-1:0]       cnt;
  logic [NORM_W-1:0]   m;
  logic [K_W-1:0]      k;
  logic [42:0]         ip;
  logic [LN_W-1:0]     kp;
  logic [LN_TAB_W-1:0] lo_r;
  logic [LN_W-1:0]     l;
  logic [L2_W-1:0]     l2;
  logic [L3_W-1:0]     l3;
  logic [PB_W-1:0]     pb;
  logic [PC_W-1:0]     pc;
  logic [D_W-1:0]      d;
  logic [D_W-1:0]      rem2;
  logic [KEL_W-1:0]    kel;
  logic [TEMP_W-1:0]   t;
  logic                flag;
  logic                inv;
  logic [TEMP_W-1:0]   held_temp;
  logic [LIMIT_W-1:0]  differ_count;
  logic                primed;

  logic [ADC_BITS:0]   rem1_sh;
  logic [NW-1:0]       r_val;
  logic [LN_TAB_W-1:0] lo_v;
  logic [LN_TAB_W-1:0] hi_v;
  logic [49:0]         sq_p;
  logic [54:0]         cu_p;
  logic [56:0]         pb_p;
  logic [54:0]         pc_p;
  logic [D_W:0]        rem2_sh;
  logic [KEL_W-1:0]    kdiff;
  logic [LIMIT_W-1:0]  cnt_inc;
  logic                slot_free;

  assign pop       = (state == S_IDLE) && head.avail;
  assign slot_free = !out_valid || out_ready;
  assign rem1_sh   = {rem1, num[NW-1]};
  assign r_val     = num - NW'(series_ohms);
  assign lo_v      = ln_tab({1'b0, m[30:27]});
  assign hi_v      = ln_tab({1'b0, m[30:27]} + 5'd1);
  assign sq_p      = 50'(l) * 50'(l);
  assign cu_p      = 55'(l2) * 55'(l);
  assign pb_p      = 57'(COEF_B) * 57'(l);
  assign pc_p      = 55'(COEF_C) * 55'(l3);
  assign rem2_sh   = {rem2, KNUM_LO[cnt[4:0]]};
  assign kdiff     = kel - ZERO_C_Q20;
  assign cnt_inc   = (differ_count == COUNT_MAX) ? COUNT_MAX : differ_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      held_temp    <= '0;
      differ_count <= '0;
      primed       <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FILT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.avail) begin
            samp  <= head_sample;
            inv   <= head.bad;
            state <= head.bad ? S_FILT : S_MUL;
          end
        end
        S_MUL: begin
          num   <= NW'({ADC_BITS{1'b1}}) * NW'(series_ohms);
          rem1  <= '0;
          cnt   <= CW'(NW - 1);
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (rem1_sh >= {1'b0, samp}) begin
            rem1 <= ADC_BITS'(rem1_sh - {1'b0, samp});
            num  <= {num[NW-2:0], 1'b1};
          end else begin
            rem1 <= rem1_sh[ADC_BITS-1:0];
            num  <= {num[NW-2:0], 1'b0};
          end
          cnt <= cnt - CW'(1);
          if (cnt == '0) state <= S_SUB;
        end
        S_SUB: begin
          m <= NORM_W'(r_val);
          k <= K_W'(NORM_W - 1);
          if (r_val == '0) begin
            inv   <= 1'b1;
            state <= S_FILT;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (m[NORM_W-1]) begin
            state <= S_LN1;
          end else begin
            m <= m << 1;
            k <= k - K_W'(1);
          end
        end
        S_LN1: begin
          ip    <= 43'(hi_v - lo_v) * 43'(m[LN_REM_W-1:0]);
          kp    <= LN_W'(k) * LN_W'(LN2_Q20);
          lo_r  <= lo_v;
          state <= S_LN2;
        end
        S_LN2: begin
          l     <= kp + LN_W'(lo_r) + LN_W'(ip[42:LN_REM_W]);
          state <= S_SQ;
        end
        S_SQ: begin
          l2    <= sq_p[49:20];
          state <= S_CUBE;
        end
        S_CUBE: begin
          l3    <= cu_p[54:20];
          state <= S_COEF;
        end
        S_COEF: begin
          pb    <= pb_p[56:20];
          pc    <= pc_p[54:20];
          state <= S_SUM;
        end
        S_SUM: begin
          d     <= D_W'(COEF_A) + pb + D_W'(pc);
          rem2  <= D_W'(KNUM_HI);
          cnt   <= CW'(KEL_W - 1);
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (rem2_sh >= {1'b0, d}) begin
            rem2 <= D_W'(rem2_sh - {1'b0, d});
            kel  <= {kel[KEL_W-2:0], 1'b1};
          end else begin
            rem2 <= rem2_sh[D_W-1:0];
            kel  <= {kel[KEL_W-2:0], 1'b0};
          end
          cnt <= cnt - CW'(1);
          if (cnt == '0) state <= S_CEL;
        end
        S_CEL: begin
          if (kel <= KEL_LOW_LIM) begin
            t    <= '0;
            flag <= 1'b1;
          end else if (kel >= KEL_HIGH_LIM) begin
            t    <= TEMP_MAX;
            flag <= 1'b1;
          end else if (kel >= ZERO_C_Q20) begin
            t    <= kdiff[26:20];
            flag <= 1'b0;
          end else begin
            t    <= '0;
            flag <= 1'b0;
          end
          state <= S_FILT;
        end
        S_FILT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (inv) begin
              shown_temp   <= held_temp;
              tens_digit   <= tens_of(held_temp);
              units_digit  <= DIGIT_W'(held_temp - TEMP_W'(tens_of(held_temp)) * 7'd10);
              out_of_range <= 1'b1;
            end else begin
              out_of_range <= flag;
              if (primed && t != held_temp && cnt_inc < change_limit) begin
                differ_count <= cnt_inc;
                shown_temp   <= held_temp;
                tens_digit   <= tens_of(held_temp);
                units_digit  <= DIGIT_W'(held_temp - TEMP_W'(tens_of(held_temp)) * 7'd10);
              end else begin
                held_temp    <= t;
                differ_count <= '0;
                primed       <= 1'b1;
                shown_temp   <= t;
                tens_digit   <= tens_of(t);
                units_digit  <= DIGIT_W'(t - TEMP_W'(tens_of(t)) * 7'd10);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shown_temp <= TEMP_MAX)
    else $error("shown temperature above clamp");
  a_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (8'(tens_digit) * 8'd10 + 8'(units_digit)) == 8'(shown_temp))
    else $error("digits disagree with shown temperature");
  a_primed_sticks: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed dropped without reset");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != S_IDLE)
    else $error("word popped but engine stayed idle");
`endif

endmodule

/* design/thermistor_temp_with_persistence.sv */
// Thermistor thermometer with persistence filter.
// Input channel: in_valid/in_ready carry one adc_sample word, the raw reading
// of the thermistor divider. Output channel: out_valid/out_ready carry one
// word per sample: shown_temp in whole degrees C (0..99), its tens and units
// digits, and out_of_range, set for a sample of zero or full scale, a zero
// resistance, or a clamped temperature.
// Configuration: wr_en writes wr_data into register wr_index (0: change_limit,
// 1: series_ohms) at a clock edge; write only while no sample is in flight.
// Steps for a valid sample: bit-serial resistance division, normalize shifts,
// log interpolation, square, cube, coefficient products, sum, bit-serial
// Kelvin division, Celsius conversion and clamp, then the filter; an invalid
// sample goes straight to the filter step. The engine works on one sample at
// a time and pops the next only when back in idle. A two-word queue in front
// keeps accepting while the engine works. When the receiver stalls, the
// result waits in the output register and the engine holds its next result
// until it is taken. Reset clears the queue, the filter state and the output
// valid, and sets change_limit to 10 and series_ohms to 10000.
module thermistor_temp_with_persistence
  import tts_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [WR_IDX_W-1:0] wr_index,
  input  logic [OHMS_W-1:0]   wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_BITS-1:0] adc_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TEMP_W-1:0]   shown_temp,
  output logic [DIGIT_W-1:0]  tens_digit,
  output logic [DIGIT_W-1:0]  units_digit,
  output logic                out_of_range
);

  logic [LIMIT_W-1:0]  change_limit;
  logic [OHMS_W-1:0]   series_ohms;
  q_head_t             head;
  logic [ADC_BITS-1:0] head_sample;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      change_limit <= LIMIT_RESET;
      series_ohms  <= OHMS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHANGE_LIMIT: change_limit <= wr_data[LIMIT_W-1:0];
        REG_SERIES_OHMS:  series_ohms  <= wr_data;
        default: ;
      endcase
    end
  end

  tts_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .adc_sample  (adc_sample),
    .pop         (pop),
    .head        (head),
    .head_sample (head_sample)
  );

  tts_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .change_limit (change_limit),
    .series_ohms  (series_ohms),
    .head         (head),
    .head_sample  (head_sample),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .shown_temp   (shown_temp),
    .tens_digit   (tens_digit),
    .units_digit  (units_digit),
    .out_of_range (out_of_range)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import tts_pkg::*;

  localparam int SAMPLE_W = 10;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;
  localparam logic [WR_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
    logic               flag;
  } reading_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                known;
    reading_t            want;
  } vector_t;

  logic clk = 0;
  logic rst = 1;
  logic wr_en = 0;
  logic [WR_IDX_W-1:0] wr_index = REG_CHANGE_LIMIT;
  logic [OHMS_W-1:0] wr_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [SAMPLE_W-1:0] adc_sample = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [TEMP_W-1:0] shown_temp;
  logic [DIGIT_W-1:0] tens_digit;
  logic [DIGIT_W-1:0] units_digit;
  logic out_of_range;

  thermistor_temp_with_persistence #(.ADC_BITS(SAMPLE_W)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [LIMIT_W-1:0] m_limit;
  logic [OHMS_W-1:0] m_ohms;
  logic [TEMP_W-1:0] m_held;
  logic [LIMIT_W-1:0] m_count;
  logic m_primed;
  reading_t pending_readings[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;

  const logic [19:0] LOG_TABLE[17] = '{
    20'd0, 20'd63570, 20'd123504, 20'd180198, 20'd233983, 20'd285143, 20'd333923,
    20'd380534, 20'd425161, 20'd467966, 20'd509092, 20'd548665, 20'd586800,
    20'd623596, 20'd659144, 20'd693527, 20'd726817};

  function automatic longint degrees_of(longint unsigned r);
    int k;
    longint unsigned m, frac, rem, lo, hi, l, l2, l3, d, kel;
    int idx;
    longint c;
    k = 0;
    while (k < 31 && (r >> (k + 1)) != 0) k++;
    m = (r << (31 - k)) & 64'hFFFF_FFFF;
    frac = m & 64'h7FFF_FFFF;
    idx = int'((frac >> 27) & 15);
    rem = frac & 64'h7FF_FFFF;
    lo = LOG_TABLE[idx];
    hi = LOG_TABLE[idx + 1];
    l = longint'(k) * 726817 + lo + (((hi - lo) * rem) >> 27);
    l2 = (l * l) >> 20;
    l3 = (l2 * l) >> 20;
    d = 64'd11291480000 + ((64'd2341250000 * l) >> 20) + ((64'd876741 * l3) >> 20);
    kel = (64'd10000000000000 << 20) / d;
    c = longint'(kel) - 64'sd286418534;
    if (c >= 0) return c >>> 20;
    return -((-c) >>> 20);
  endfunction

  function automatic reading_t filter_sample(logic [SAMPLE_W-1:0] s);
    reading_t o;
    longint unsigned r;
    longint deg;
    logic [TEMP_W-1:0] t, shown;
    logic flag;
    flag = 0;
    r = 0;
    if (s != 0 && s != FULL_SCALE)
      r = (longint'(FULL_SCALE) * m_ohms) / s - m_ohms;
    if (r == 0) begin
      shown = m_held;
      flag = 1;
    end else begin
      deg = degrees_of(r);
      if (deg < 0) begin
        t = 0;
        flag = 1;
      end else if (deg > 99) begin
        t = TEMP_MAX;
        flag = 1;
      end else begin
        t = TEMP_W'(deg);
      end
      if (!m_primed) begin
        m_held = t;
        m_count = 0;
        m_primed = 1;
        shown = t;
      end else if (t != m_held) begin
        if (m_count < COUNT_MAX) m_count++;
        if (m_count < m_limit) begin
          shown = m_held;
        end else begin
          m_held = t;
          m_count = 0;
          shown = t;
        end
      end else begin
        m_count = 0;
        shown = t;
      end
    end
    o.temp = shown;
    o.tens = DIGIT_W'(shown / 10);
    o.units = DIGIT_W'(shown % 10);
    o.flag = flag;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    reading_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected word", shown_temp, -1);
      end else begin
        w = pending_readings.pop_front();
        if (shown_temp !== w.temp) report_mismatch("shown_temp", shown_temp, w.temp);
        if (tens_digit !== w.tens) report_mismatch("tens_digit", tens_digit, w.tens);
        if (units_digit !== w.units) report_mismatch("units_digit", units_digit, w.units);
        if (out_of_range !== w.flag) report_mismatch("out_of_range", out_of_range, w.flag);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [WR_IDX_W-1:0] idx, logic [OHMS_W-1:0] val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    if (idx == REG_CHANGE_LIMIT) m_limit = val[LIMIT_W-1:0];
    else if (idx == REG_SERIES_OHMS) m_ohms = val;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] s, bit known, reading_t want);
    reading_t p;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1;
    adc_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = filter_sample(s);
    if (known && p != want) report_mismatch("model table", p.temp, want.temp);
    pending_readings.push_back(p);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0: return SAMPLE_W'($urandom_range(3));
      1: return FULL_SCALE - SAMPLE_W'($urandom_range(2));
      2, 3, 4: return SAMPLE_W'($urandom_range(700, 300));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  vector_t directed[] = '{
    '{10'd0, 1, '{7'd0, 4'd0, 4'd0, 1'b1}},
    '{10'd1023, 1, '{7'd0, 4'd0, 4'd0, 1'b1}},
    '{10'd512, 0, '{default: 0}},
    '{10'd512, 0, '{default: 0}},
    '{10'd600, 0, '{default: 0}},
    '{10'd1, 0, '{default: 0}},
    '{10'd1022, 0, '{default: 0}},
    '{10'd300, 0, '{default: 0}},
    '{10'd700, 0, '{default: 0}},
    '{10'd900, 0, '{default: 0}},
    '{10'd100, 0, '{default: 0}},
    '{10'd512, 0, '{default: 0}},
    '{10'd1023, 0, '{default: 0}},
    '{10'd0, 0, '{default: 0}}
  };

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    reading_t none;
    int phase;
    logic [SAMPLE_W-1:0] s;
    none = '{default: 0};
    m_limit = LIMIT_RESET;
    m_ohms = OHMS_RESET;
    m_held = 0;
    m_count = 0;
    m_primed = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_sample(directed[i].sample, directed[i].known, directed[i].want);
    repeat (8) send_sample(10'd550 + SAMPLE_W'(($urandom_range(1) * 100)), 0, none);
    drain();
    write_reg(REG_CHANGE_LIMIT, 16'd1);
    write_reg(REG_SERIES_OHMS, 16'd65535);
    repeat (6) send_sample(random_sample(), 0, none);
    drain();
    write_reg(REG_SERIES_OHMS, 16'd1);
    write_reg(REG_CHANGE_LIMIT, 16'd255);
    repeat (6) send_sample(random_sample(), 0, none);
    drain();
    write_reg(REG_CHANGE_LIMIT, 16'd0);
    write_reg(REG_SERIES_OHMS, 16'd0);
    repeat (4) send_sample(random_sample(), 0, none);
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_SERIES_OHMS, OHMS_RESET);
    hold_off = 600;
    repeat (8) send_sample(random_sample(), 0, none);
    for (phase = 0; phase < 8; phase++) begin
      drain();
      write_reg(REG_CHANGE_LIMIT, OHMS_W'($urandom_range(phase == 0 ? 255 : 12, 1)));
      write_reg(REG_SERIES_OHMS, OHMS_W'($urandom_range(phase == 1 ? 65535 : 30000, 1)));
      send_idle = (phase % 4 == 1 || phase % 4 == 3) ? 76 : 0;
      recv_stall = (phase % 4 == 2) ? 76 : (phase % 4 == 3 ? 20 : 0);
      if (phase % 4 == 3) send_idle = 20;
      repeat (83) begin
        s = random_sample();
        repeat ($urandom_range(6)) send_sample(s ^ SAMPLE_W'($urandom_range(1)), 0, none);
      end
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/tts_pkg.sv
design/tts_front.sv
design/tts_back.sv
design/thermistor_temp_with_persistence.sv
dv/tb_top.sv
